FILE: sv/nalsp_pkg.sv
// shared types and constants of the annex-b nal unit splitter
// no dependencies
package nalsp_pkg;

  localparam int LENGTH_BITS_DEF      = 24;
  localparam int QUEUE_COUNT_BITS_DEF = 16;
  localparam int EVQ_DEPTH            = 4;

  localparam logic [4:0]  NAL_TYPE_MASK   = 5'h1F;
  localparam logic [7:0]  START_BYTE      = 8'h01;
  localparam logic [7:0]  ZERO_BYTE       = 8'h00;
  localparam logic [23:0] MAX_LEN_RESET   = 24'd524288;
  localparam logic [15:0] MAX_QUEUE_RESET = 16'd64;
  localparam logic [23:0] OUT_LEN_MAX     = 24'hFFFFFF;

  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_SHORT = 3'd3;
  localparam logic [2:0] CODE_LONG  = 3'd4;

  localparam logic [2:0] VERD_QUEUED    = 3'd0;
  localparam logic [2:0] VERD_TOO_LONG  = 3'd1;
  localparam logic [2:0] VERD_FULL      = 3'd2;
  localparam logic [2:0] VERD_DEQUEUED  = 3'd3;
  localparam logic [2:0] VERD_DEQ_EMPTY = 3'd4;

  localparam logic REG_MAX_LEN   = 1'b0;
  localparam logic REG_MAX_QUEUE = 1'b1;

  // request handed from the parser to the queue accounting
  typedef struct packed {
    logic        is_deq;
    logic [2:0]  code_len;
    logic [4:0]  nal_type;
    logic [31:0] frame;
    logic        key;
  } evt_t;

endpackage

FILE: sv/annexb_nal_unit_splitter_top.sv
// annex-b nal unit splitter top: config registers, parser, request queue, accounting
// depends on nalsp_pkg, nalsp_front, nalsp_evq, nalsp_back
//
//   channel   handshake        payload
//   input     push / full      in_req_type, in_data_byte, in_frame_last, in_key_frame
//   result    empty / pop      out_verdict .. out_key_frame_out
//   config    psel .. pready   paddr, pwdata, prdata
//
// one request per cycle unless full; results pass request queue, then result register
// parser updates in the accept cycle; one verdict and count update a cycle unless result held
// full rises only when the four-entry request queue fills while results are not popped
// reset is synchronous and needs no clearing pass
module annexb_nal_unit_splitter_top #(
  parameter int LENGTH_BITS      = nalsp_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_COUNT_BITS = nalsp_pkg::QUEUE_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_last,
  input  logic        in_key_frame,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_verdict,
  output logic [4:0]  out_nal_type,
  output logic [23:0] out_nal_length,
  output logic [2:0]  out_start_code_len,
  output logic [15:0] out_occupancy,
  output logic [31:0] out_frame_number,
  output logic        out_key_frame_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nalsp_pkg::*;

  localparam int EW = LENGTH_BITS + $bits(evt_t);

  logic [23:0] max_len_r;
  logic [15:0] max_queue_r;
  logic        cfg_wr;

  logic                   accept;
  logic                   fe_valid;
  evt_t                   fe_evt;
  logic [LENGTH_BITS-1:0] fe_len;
  logic [EW-1:0]          q_rd;
  logic                   q_valid;
  logic                   q_pop;
  evt_t                   be_evt;
  logic [LENGTH_BITS-1:0] be_len;
  logic                   out_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_QUEUE) ? {16'd0, max_queue_r} : {8'd0, max_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RESET;
      max_queue_r <= MAX_QUEUE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_LEN) begin
        max_len_r <= pwdata[23:0];
      end else begin
        max_queue_r <= pwdata[15:0];
      end
    end
  end

  assign accept = push && !full;

  nalsp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .data_byte (in_data_byte),
    .frame_last(in_frame_last),
    .key_frame (in_key_frame),
    .evt_valid (fe_valid),
    .evt       (fe_evt),
    .evt_len   (fe_len)
  );

  nalsp_evq #(
    .WIDTH(EW),
    .DEPTH(EVQ_DEPTH)
  ) u_evq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fe_valid),
    .wr_data({fe_len, fe_evt}),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(q_rd),
    .valid  (q_valid)
  );

  assign be_len = q_rd[EW-1 -: LENGTH_BITS];
  assign be_evt = evt_t'(q_rd[$bits(evt_t)-1:0]);

  nalsp_back #(
    .LENGTH_BITS     (LENGTH_BITS),
    .QUEUE_COUNT_BITS(QUEUE_COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt_valid     (q_valid),
    .evt           (be_evt),
    .evt_len       (be_len),
    .evt_pop       (q_pop),
    .max_len       (max_len_r),
    .max_queue     (max_queue_r),
    .out_valid     (out_valid),
    .out_pop       (pop),
    .verdict       (out_verdict),
    .nal_type      (out_nal_type),
    .nal_length    (out_nal_length),
    .start_code_len(out_start_code_len),
    .occupancy     (out_occupancy),
    .frame_number  (out_frame_number),
    .key_frame_out (out_key_frame_out)
  );

  assign empty = !out_valid;

  // a dequeue on an empty queue leaves it empty
  a_deq_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_verdict == VERD_DEQ_EMPTY) |-> (out_occupancy == 16'd0))
    else $error("dequeue on empty queue reported nonzero occupancy");

  // a queued nal leaves at least one entry waiting
  a_queued_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_verdict == VERD_QUEUED) |-> (out_occupancy != 16'd0))
    else $error("queued nal reported zero occupancy");

  // nal results always carry a three or four byte start code
  a_nal_code_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_verdict == VERD_QUEUED || out_verdict == VERD_TOO_LONG ||
                out_verdict == VERD_FULL))
    |-> (out_start_code_len == CODE_SHORT || out_start_code_len == CODE_LONG))
    else $error("nal result with bad start code length");

  // a held result is not overwritten by the accounting stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |-> !q_pop)
    else $error("result register overrun");

endmodule

FILE: sv/nalsp_front.sv
// start code parser: classifies each request and closes nal units
// depends on nalsp_pkg
module nalsp_front #(
  parameter int LENGTH_BITS = nalsp_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   req_type,
  input  logic [7:0]             data_byte,
  input  logic                   frame_last,
  input  logic                   key_frame,
  output logic                   evt_valid,
  output nalsp_pkg::evt_t        evt,
  output logic [LENGTH_BITS-1:0] evt_len
);
  import nalsp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_ALL = '1;

  logic [23:0]            window_r, window_nxt;
  logic [1:0]             fill_r, fill_nxt;
  logic                   in_nal_r, in_nal_nxt;
  logic                   await_r, await_nxt;
  logic [4:0]             type_r, type_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [2:0]             code_len_r, code_len_nxt;
  logic [31:0]            frame_r, frame_nxt;

  logic [2:0]             code;
  logic [LENGTH_BITS-1:0] len_inc;
  logic                   emit;
  logic [LENGTH_BITS-1:0] emit_len;
  logic [4:0]             emit_type;

  always_comb begin
    code = CODE_NONE;
    if (fill_r >= 2'd2 && window_r[15:8] == ZERO_BYTE && window_r[7:0] == ZERO_BYTE &&
        data_byte == START_BYTE) begin
      code = CODE_SHORT;
      if (fill_r == 2'd3 && window_r[23:16] == ZERO_BYTE) begin
        code = CODE_LONG;
      end
    end
  end

  assign len_inc = (len_r == LEN_ALL) ? len_r : len_r + 1'b1;

  always_comb begin
    window_nxt   = window_r;
    fill_nxt     = fill_r;
    in_nal_nxt   = in_nal_r;
    await_nxt    = await_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    code_len_nxt = code_len_r;
    frame_nxt    = frame_r;
    emit         = 1'b0;
    emit_len     = len_inc;
    emit_type    = type_r;
    if (accept && !req_type) begin
      if (in_nal_r) begin
        len_nxt = len_inc;
        if (await_r) begin
          type_nxt  = data_byte[4:0] & NAL_TYPE_MASK;
          await_nxt = 1'b0;
        end else if (code != CODE_NONE) begin
          emit     = 1'b1;
          emit_len = (len_inc == LEN_ALL) ? LEN_ALL : len_inc - LENGTH_BITS'(code);
        end
      end
      if (code != CODE_NONE) begin
        in_nal_nxt   = 1'b1;
        await_nxt    = 1'b1;
        len_nxt      = LENGTH_BITS'(code);
        code_len_nxt = code;
      end
      window_nxt = {window_r[15:0], data_byte};
      if (fill_r != 2'd3) begin
        fill_nxt = fill_r + 2'd1;
      end
      if (frame_last) begin
        if (!emit && in_nal_nxt && !await_nxt) begin
          emit      = 1'b1;
          emit_len  = len_nxt;
          emit_type = type_nxt;
        end
        window_nxt   = '0;
        fill_nxt     = '0;
        in_nal_nxt   = 1'b0;
        await_nxt    = 1'b0;
        type_nxt     = '0;
        len_nxt      = '0;
        code_len_nxt = '0;
        frame_nxt    = frame_r + 32'd1;
      end
    end
  end

  always_comb begin
    evt_valid    = accept && (req_type || emit);
    evt.is_deq   = req_type;
    evt.code_len = code_len_r;
    evt.nal_type = emit_type;
    evt.frame    = frame_r;
    evt.key      = key_frame;
    evt_len      = emit_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '0;
      fill_r     <= '0;
      in_nal_r   <= 1'b0;
      await_r    <= 1'b0;
      type_r     <= '0;
      len_r      <= '0;
      code_len_r <= '0;
      frame_r    <= '0;
    end else begin
      window_r   <= window_nxt;
      fill_r     <= fill_nxt;
      in_nal_r   <= in_nal_nxt;
      await_r    <= await_nxt;
      type_r     <= type_nxt;
      len_r      <= len_nxt;
      code_len_r <= code_len_nxt;
      frame_r    <= frame_nxt;
    end
  end

endmodule

FILE: sv/nalsp_evq.sv
// short request queue between parser and queue accounting
// depends on nalsp_pkg
module nalsp_evq #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nalsp_pkg::EVQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);
  import nalsp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: sv/nalsp_back.sv
// queue accounting: verdicts, occupancy and the result register
// depends on nalsp_pkg
module nalsp_back #(
  parameter int LENGTH_BITS      = nalsp_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_COUNT_BITS = nalsp_pkg::QUEUE_COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   evt_valid,
  input  nalsp_pkg::evt_t        evt,
  input  logic [LENGTH_BITS-1:0] evt_len,
  output logic                   evt_pop,
  input  logic [23:0]            max_len,
  input  logic [15:0]            max_queue,
  output logic                   out_valid,
  input  logic                   out_pop,
  output logic [2:0]             verdict,
  output logic [4:0]             nal_type,
  output logic [23:0]            nal_length,
  output logic [2:0]             start_code_len,
  output logic [15:0]            occupancy,
  output logic [31:0]            frame_number,
  output logic                   key_frame_out
);
  import nalsp_pkg::*;

  localparam int LCW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;
  localparam int QOW = (QUEUE_COUNT_BITS > 16) ? QUEUE_COUNT_BITS : 16;
  localparam int QW  = QOW + 1;
  localparam logic [QUEUE_COUNT_BITS-1:0] QCNT_ALL = '1;

  logic [QUEUE_COUNT_BITS-1:0] qcnt_r, qcnt_nxt;
  logic                        valid_r;
  logic [2:0]                  verdict_r, verdict_nxt;
  logic [4:0]                  type_r;
  logic [23:0]                 len_r;
  logic [2:0]                  code_len_r;
  logic [15:0]                 occ_r;
  logic [31:0]                 frame_r;
  logic                        key_r;

  logic [LCW-1:0] len_ext;
  logic [23:0]    len_out;
  logic           too_long;
  logic           q_full;
  logic [QOW-1:0] occ_ext;

  assign evt_pop  = evt_valid && (!valid_r || out_pop);
  assign len_ext  = LCW'(evt_len);
  assign too_long = len_ext > LCW'(max_len);
  assign len_out  = (len_ext > LCW'(OUT_LEN_MAX)) ? OUT_LEN_MAX : len_ext[23:0];
  assign q_full   = (qcnt_r == QCNT_ALL) || ((QW'(qcnt_r) + 1'b1) > QW'(max_queue));
  assign occ_ext  = QOW'(qcnt_nxt);

  always_comb begin
    qcnt_nxt    = qcnt_r;
    verdict_nxt = VERD_QUEUED;
    if (evt.is_deq) begin
      if (qcnt_r != '0) begin
        qcnt_nxt    = qcnt_r - 1'b1;
        verdict_nxt = VERD_DEQUEUED;
      end else begin
        verdict_nxt = VERD_DEQ_EMPTY;
      end
    end else if (too_long) begin
      verdict_nxt = VERD_TOO_LONG;
    end else if (q_full) begin
      verdict_nxt = VERD_FULL;
    end else begin
      qcnt_nxt = qcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (evt_pop) begin
        qcnt_r  <= qcnt_nxt;
        valid_r <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      verdict_r  <= verdict_nxt;
      occ_r      <= occ_ext[15:0];
      type_r     <= evt.is_deq ? '0 : evt.nal_type;
      len_r      <= evt.is_deq ? '0 : len_out;
      code_len_r <= evt.is_deq ? '0 : evt.code_len;
      frame_r    <= evt.is_deq ? '0 : evt.frame;
      key_r      <= evt.is_deq ? 1'b0 : evt.key;
    end
  end

  assign out_valid      = valid_r;
  assign verdict        = verdict_r;
  assign nal_type       = type_r;
  assign nal_length     = len_r;
  assign start_code_len = code_len_r;
  assign occupancy      = occ_r;
  assign frame_number   = frame_r;
  assign key_frame_out  = key_r;

endmodule
